[rtl/sphere_triangle_overlap_top_defines.svh]
// Assertion macros used by the sphere-triangle overlap top level.
`ifndef SPHERE_TRIANGLE_OVERLAP_TOP_DEFINES_SVH
`define SPHERE_TRIANGLE_OVERLAP_TOP_DEFINES_SVH

// Check a same-cycle implication, ignored while reset is asserted.
`define STO_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, ignored while reset is asserted.
`define STO_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sto_pkg.sv]
// Shared widths and types of the sphere-triangle overlap pipeline.
package sto_pkg;

    localparam int COORD_BITS = 16;
    localparam int CW         = COORD_BITS;
    localparam int DFW        = CW + 1;          // coordinate difference
    localparam int DTW        = 2 * DFW + 2;     // dot product of differences
    localparam int NW         = 2 * DFW + 1;     // face normal component
    localparam int VW         = 2 * DTW + 1;     // barycentric cross terms
    localparam int NAPW       = NW + DFW + 2;    // normal dot (P - A)
    localparam int NNW        = 2 * NW + 2;      // squared normal length
    localparam int R2W        = 2 * CW;          // squared radius
    localparam int RW         = 3;               // region code

    localparam int GEO_STG    = 3;
    localparam int DST_STG    = 4;
    localparam int NSTG       = GEO_STG + DST_STG;

    typedef struct packed {
        logic signed [CW-1:0] x, y, z;
    } t_vec;

    typedef struct packed {
        t_vec a, b, c;
    } t_tri;

    typedef struct packed {
        logic signed [DTW-1:0]  d1, d2, d3, d4, d5, d6;
        logic signed [DTW-1:0]  aa, bb, eab, eac, ebc, vbc;
        logic signed [VW-1:0]   vc, vb, va;
        logic signed [NAPW-1:0] nap;
        logic signed [NNW-1:0]  nn;
        logic                   hit_a, hit_b, hit_c;
    } t_geo;

endpackage

[rtl/sphere_triangle_overlap_top.sv]
// Top level of the sphere-triangle overlap tester: APB registers, pipeline control.
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  --------------------------------------
//  input     in         i_valid / o_stall    i_vert_{a,b,c}_{x,y,z}, signed 16 bit
//  output    out        o_valid / i_stall    o_hit, o_nearest_region (3 bit)
//  config    in/out     psel/penable/pready  center_x/y/z, sphere_radius at 0x0..0xC
//
// One request per cycle sustained while i_stall stays low; each request passes through
// the seven register stages of the geometry and distance datapaths before o_valid.
// Reset (i_rst_n low at a clock edge) empties the pipeline and clears the sphere.
// A stall on the output parks results in place; upstream stages keep filling
// bubbles, and o_stall rises only when every stage holds a request.
// Configuration is read directly by the pipeline: write it only when idle.
`include "sphere_triangle_overlap_top_defines.svh"

module sphere_triangle_overlap_top import sto_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // triangle requests
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [CW-1:0] i_vert_a_x,
    input  logic signed [CW-1:0] i_vert_a_y,
    input  logic signed [CW-1:0] i_vert_a_z,
    input  logic signed [CW-1:0] i_vert_b_x,
    input  logic signed [CW-1:0] i_vert_b_y,
    input  logic signed [CW-1:0] i_vert_b_z,
    input  logic signed [CW-1:0] i_vert_c_x,
    input  logic signed [CW-1:0] i_vert_c_y,
    input  logic signed [CW-1:0] i_vert_c_z,
    // results
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_hit,
    output logic [RW-1:0]        o_nearest_region
);

    localparam logic [1:0] CFG_CX  = 2'd0;
    localparam logic [1:0] CFG_CY  = 2'd1;
    localparam logic [1:0] CFG_CZ  = 2'd2;
    localparam logic [1:0] CFG_RAD = 2'd3;

    // ---------------------------------------------------------------------------------
    // Configuration registers. The squared radius is registered from the radius
    // register and settles well before any request needs it.
    // ---------------------------------------------------------------------------------
    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    logic [CW-1:0]        r_rad;
    logic [R2W-1:0]       r_r2;
    logic                 w_wr;
    logic [1:0]           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                CFG_CX:  r_cx  <= pwdata[CW-1:0];
                CFG_CY:  r_cy  <= pwdata[CW-1:0];
                CFG_CZ:  r_cz  <= pwdata[CW-1:0];
                CFG_RAD: r_rad <= pwdata[CW-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r2 <= '0;
        end else begin
            r_r2 <= R2W'(r_rad) * R2W'(r_rad);
        end
    end

    // Centers read back sign-extended, radius zero-extended.
    always_comb begin
        unique case (w_idx)
            CFG_CX:  prdata = 32'(r_cx);
            CFG_CY:  prdata = 32'(r_cy);
            CFG_CZ:  prdata = 32'(r_cz);
            CFG_RAD: prdata = 32'(r_rad);
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Pipeline control. Stage k advances when it is empty or the stage after it
    // advances; the last stage advances when the consumer does not stall. Data
    // registers in the submodules load on the same enables, so a valid bit and
    // its payload always move together and a parked request is never overwritten.
    // ---------------------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_rdy;
    logic            w_in_acc;
    logic            w_out_acc;

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        n_vld[0] = w_rdy[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall   = !w_rdy[0];
    assign o_valid   = r_vld[NSTG-1];
    assign w_in_acc  = i_valid && w_rdy[0];
    assign w_out_acc = o_valid && !i_stall;

    // ---------------------------------------------------------------------------------
    // Datapath: three geometry stages (differences, dot products, cross terms),
    // then four distance stages (region select, products, sums, compare).
    // ---------------------------------------------------------------------------------
    t_tri w_tri;
    t_vec w_center;
    t_geo w_geo;

    assign w_tri.a.x    = i_vert_a_x;
    assign w_tri.a.y    = i_vert_a_y;
    assign w_tri.a.z    = i_vert_a_z;
    assign w_tri.b.x    = i_vert_b_x;
    assign w_tri.b.y    = i_vert_b_y;
    assign w_tri.b.z    = i_vert_b_z;
    assign w_tri.c.x    = i_vert_c_x;
    assign w_tri.c.y    = i_vert_c_y;
    assign w_tri.c.z    = i_vert_c_z;
    assign w_center.x   = r_cx;
    assign w_center.y   = r_cy;
    assign w_center.z   = r_cz;

    sto_geom u_geom (
        .i_clk    (i_clk),
        .i_en     (w_rdy[GEO_STG-1:0]),
        .i_tri    (w_tri),
        .i_center (w_center),
        .i_r2     (r_r2),
        .o_geo    (w_geo)
    );

    sto_dist u_dist (
        .i_clk    (i_clk),
        .i_en     (w_rdy[NSTG-1:GEO_STG]),
        .i_geo    (w_geo),
        .i_r2     (r_r2),
        .o_hit    (o_hit),
        .o_region (o_nearest_region)
    );

    // ---------------------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------------------
    // Hold off the producer only when every stage is full and the output is stalled.
    `STO_ASSERT_NOW(a_stall_only_full, i_clk, i_rst_n, o_stall, (&r_vld) && i_stall,
        "input stalled while the pipeline has a free stage")
    // Occupancy changes only by requests taken in and results handed out.
    `STO_ASSERT_NEXT(a_occupancy, i_clk, i_rst_n, 1'b1,
        $countones(r_vld) == $past($countones(r_vld)) + int'($past(w_in_acc))
            - int'($past(w_out_acc)),
        "pipeline lost or duplicated a request")
    // An accepted request lands in the first stage.
    `STO_ASSERT_NEXT(a_enter, i_clk, i_rst_n, w_in_acc, r_vld[0],
        "accepted request missing from the first stage")

endmodule

[rtl/sto_geom.sv]
// Geometry stages: edge vectors, dot products, barycentric terms, face normal.
module sto_geom import sto_pkg::*; (
    input  logic               i_clk,
    input  logic [GEO_STG-1:0] i_en,
    input  t_tri               i_tri,
    input  t_vec               i_center,
    input  logic [R2W-1:0]     i_r2,
    output t_geo               o_geo
);

    typedef struct packed {
        logic signed [DFW-1:0] x, y, z;
    } t_dvec;

    typedef struct packed {
        logic signed [NW-1:0] x, y, z;
    } t_nvec;

    function automatic t_dvec vsub(input t_vec u, input t_vec v);
        t_dvec r;
        r.x = DFW'($signed(u.x)) - DFW'($signed(v.x));
        r.y = DFW'($signed(u.y)) - DFW'($signed(v.y));
        r.z = DFW'($signed(u.z)) - DFW'($signed(v.z));
        return r;
    endfunction

    function automatic logic signed [DTW-1:0] dot3(input t_dvec u, input t_dvec v);
        logic signed [DTW-1:0] px, py, pz;
        px = DTW'($signed(u.x)) * DTW'($signed(v.x));
        py = DTW'($signed(u.y)) * DTW'($signed(v.y));
        pz = DTW'($signed(u.z)) * DTW'($signed(v.z));
        return px + py + pz;
    endfunction

    function automatic logic signed [NW-1:0] xprod(
        input logic signed [DFW-1:0] a1, b1, a2, b2
    );
        return NW'(a1) * NW'(b1) - NW'(a2) * NW'(b2);
    endfunction

    // stage 1: difference vectors
    t_dvec r_s1_ab, r_s1_ac, r_s1_bc, r_s1_ap, r_s1_bp, r_s1_cp;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_ab <= vsub(i_tri.b, i_tri.a);
            r_s1_ac <= vsub(i_tri.c, i_tri.a);
            r_s1_bc <= vsub(i_tri.c, i_tri.b);
            r_s1_ap <= vsub(i_center, i_tri.a);
            r_s1_bp <= vsub(i_center, i_tri.b);
            r_s1_cp <= vsub(i_center, i_tri.c);
        end
    end

    // stage 2: dot products and normal
    logic signed [DTW-1:0] r_s2_d1, r_s2_d2, r_s2_d3, r_s2_d4, r_s2_d5, r_s2_d6;
    logic signed [DTW-1:0] r_s2_aa, r_s2_bb, r_s2_cc;
    logic signed [DTW-1:0] r_s2_eab, r_s2_eac, r_s2_ebc, r_s2_vbc;
    t_nvec                 r_s2_n;
    t_dvec                 r_s2_ap;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s2_d1  <= dot3(r_s1_ab, r_s1_ap);
            r_s2_d2  <= dot3(r_s1_ac, r_s1_ap);
            r_s2_d3  <= dot3(r_s1_ab, r_s1_bp);
            r_s2_d4  <= dot3(r_s1_ac, r_s1_bp);
            r_s2_d5  <= dot3(r_s1_ab, r_s1_cp);
            r_s2_d6  <= dot3(r_s1_ac, r_s1_cp);
            r_s2_aa  <= dot3(r_s1_ap, r_s1_ap);
            r_s2_bb  <= dot3(r_s1_bp, r_s1_bp);
            r_s2_cc  <= dot3(r_s1_cp, r_s1_cp);
            r_s2_eab <= dot3(r_s1_ab, r_s1_ab);
            r_s2_eac <= dot3(r_s1_ac, r_s1_ac);
            r_s2_ebc <= dot3(r_s1_bc, r_s1_bc);
            r_s2_vbc <= dot3(r_s1_bp, r_s1_bc);
            r_s2_n.x <= xprod(r_s1_ab.y, r_s1_ac.z, r_s1_ab.z, r_s1_ac.y);
            r_s2_n.y <= xprod(r_s1_ab.z, r_s1_ac.x, r_s1_ab.x, r_s1_ac.z);
            r_s2_n.z <= xprod(r_s1_ab.x, r_s1_ac.y, r_s1_ab.y, r_s1_ac.x);
            r_s2_ap  <= r_s1_ap;
        end
    end

    // stage 3: barycentric cross terms, face projections, vertex distances
    logic signed [DTW-1:0] w_r2s;
    t_geo                  n_s3;
    t_geo                  r_s3;

    assign w_r2s = DTW'($signed({1'b0, i_r2}));

    always_comb begin
        n_s3.d1    = r_s2_d1;
        n_s3.d2    = r_s2_d2;
        n_s3.d3    = r_s2_d3;
        n_s3.d4    = r_s2_d4;
        n_s3.d5    = r_s2_d5;
        n_s3.d6    = r_s2_d6;
        n_s3.aa    = r_s2_aa;
        n_s3.bb    = r_s2_bb;
        n_s3.eab   = r_s2_eab;
        n_s3.eac   = r_s2_eac;
        n_s3.ebc   = r_s2_ebc;
        n_s3.vbc   = r_s2_vbc;
        n_s3.vc    = VW'(r_s2_d1) * VW'(r_s2_d4) - VW'(r_s2_d3) * VW'(r_s2_d2);
        n_s3.vb    = VW'(r_s2_d5) * VW'(r_s2_d2) - VW'(r_s2_d1) * VW'(r_s2_d6);
        n_s3.va    = VW'(r_s2_d3) * VW'(r_s2_d6) - VW'(r_s2_d5) * VW'(r_s2_d4);
        n_s3.nap   = NAPW'($signed(r_s2_n.x)) * NAPW'($signed(r_s2_ap.x))
                   + NAPW'($signed(r_s2_n.y)) * NAPW'($signed(r_s2_ap.y))
                   + NAPW'($signed(r_s2_n.z)) * NAPW'($signed(r_s2_ap.z));
        n_s3.nn    = NNW'($signed(r_s2_n.x)) * NNW'($signed(r_s2_n.x))
                   + NNW'($signed(r_s2_n.y)) * NNW'($signed(r_s2_n.y))
                   + NNW'($signed(r_s2_n.z)) * NNW'($signed(r_s2_n.z));
        n_s3.hit_a = (r_s2_aa <= w_r2s);
        n_s3.hit_b = (r_s2_bb <= w_r2s);
        n_s3.hit_c = (r_s2_cc <= w_r2s);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s3 <= n_s3;
        end
    end

    assign o_geo = r_s3;

endmodule

[rtl/sto_dist.sv]
// Distance stages: region select, squared-distance products and the final compare.
module sto_dist import sto_pkg::*; (
    input  logic               i_clk,
    input  logic [DST_STG-1:0] i_en,
    input  t_geo               i_geo,
    input  logic [R2W-1:0]     i_r2,
    output logic               o_hit,
    output logic [RW-1:0]      o_region
);

    localparam logic [RW-1:0] REG_VA   = RW'(0);
    localparam logic [RW-1:0] REG_VB   = RW'(1);
    localparam logic [RW-1:0] REG_AB   = RW'(2);
    localparam logic [RW-1:0] REG_VC   = RW'(3);
    localparam logic [RW-1:0] REG_AC   = RW'(4);
    localparam logic [RW-1:0] REG_BC   = RW'(5);
    localparam logic [RW-1:0] REG_FACE = RW'(6);

    localparam int PVW  = 2 * DTW;
    localparam int EW   = PVW + 1;
    localparam int RPW  = R2W + DTW + 1;
    localparam int NAPL = NAPW / 2;
    localparam int NAPH = NAPW - NAPL;
    localparam int NNL  = NNW / 2;
    localparam int NNH  = NNW - NNL;
    localparam int HHW  = 2 * NAPH;
    localparam int HLW  = NAPH + NAPL;
    localparam int LLW  = 2 * NAPL;
    localparam int SHW  = R2W + NNH;
    localparam int SLW  = R2W + NNL;
    localparam int FW   = 2 * NAPW;

    typedef struct packed {
        logic [RW-1:0] region;
        logic          base;
        logic          edge_en;
        logic          face_en;
    } t_tag;

    function automatic logic dle0(input logic signed [DTW-1:0] x);
        return x[DTW-1] || (x == '0);
    endfunction

    function automatic logic vle0(input logic signed [VW-1:0] x);
        return x[VW-1] || (x == '0);
    endfunction

    // stage 4: region, edge operand select
    t_tag                  n_s4_tag;
    logic signed [DTW-1:0] n_s4_vv, n_s4_ee, n_s4_ve;
    logic                  n_fall, n_edge, n_ezero;
    logic [NAPW-1:0]       n_s4_napmag;

    t_tag                  r_s4_tag;
    logic signed [DTW-1:0] r_s4_vv, r_s4_ee, r_s4_ve;
    logic [NAPW-1:0]       r_s4_napmag;
    logic [NNW-1:0]        r_s4_nn;

    always_comb begin
        priority if (dle0(i_geo.d1) && dle0(i_geo.d2)) begin
            n_s4_tag.region = REG_VA;
        end else if (!i_geo.d3[DTW-1] && (i_geo.d4 <= i_geo.d3)) begin
            n_s4_tag.region = REG_VB;
        end else if (vle0(i_geo.vc) && !i_geo.d1[DTW-1] && dle0(i_geo.d3)) begin
            n_s4_tag.region = REG_AB;
        end else if (!i_geo.d6[DTW-1] && (i_geo.d5 <= i_geo.d6)) begin
            n_s4_tag.region = REG_VC;
        end else if (vle0(i_geo.vb) && !i_geo.d2[DTW-1] && dle0(i_geo.d6)) begin
            n_s4_tag.region = REG_AC;
        end else if (vle0(i_geo.va) && (i_geo.d4 >= i_geo.d3)
                     && (i_geo.d5 >= i_geo.d6)) begin
            n_s4_tag.region = REG_BC;
        end else begin
            n_s4_tag.region = REG_FACE;
        end

        // edge operands: squared start-vertex distance, squared length, projection
        unique case (n_s4_tag.region)
            REG_AB: begin
                n_s4_vv = i_geo.aa;  n_s4_ee = i_geo.eab; n_s4_ve = i_geo.d1;
                n_fall  = i_geo.hit_a; n_edge = 1'b1;
            end
            REG_AC: begin
                n_s4_vv = i_geo.aa;  n_s4_ee = i_geo.eac; n_s4_ve = i_geo.d2;
                n_fall  = i_geo.hit_a; n_edge = 1'b1;
            end
            REG_BC: begin
                n_s4_vv = i_geo.bb;  n_s4_ee = i_geo.ebc; n_s4_ve = i_geo.vbc;
                n_fall  = i_geo.hit_b; n_edge = 1'b1;
            end
            default: begin
                n_s4_vv = i_geo.aa;  n_s4_ee = i_geo.eab; n_s4_ve = i_geo.d1;
                n_fall  = 1'b0;        n_edge = 1'b0;
            end
        endcase

        // a degenerate edge falls back to its start vertex
        n_ezero          = (n_s4_ee == '0);
        n_s4_tag.base    = i_geo.hit_a
                        || ((n_s4_tag.region == REG_VB) && i_geo.hit_b)
                        || ((n_s4_tag.region == REG_VC) && i_geo.hit_c)
                        || (n_edge && n_ezero && n_fall);
        n_s4_tag.edge_en = n_edge && !n_ezero;
        n_s4_tag.face_en = (n_s4_tag.region == REG_FACE) && (i_geo.nn != '0);
        n_s4_napmag      = i_geo.nap[NAPW-1] ? ((~i_geo.nap) + NAPW'(1)) : i_geo.nap;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s4_tag    <= n_s4_tag;
            r_s4_vv     <= n_s4_vv;
            r_s4_ee     <= n_s4_ee;
            r_s4_ve     <= n_s4_ve;
            r_s4_napmag <= n_s4_napmag;
            r_s4_nn     <= i_geo.nn;
        end
    end

    // stage 5: partial products
    t_tag                  r_s5_tag;
    logic signed [PVW-1:0] r_s5_vvee, r_s5_vesq;
    logic signed [RPW-1:0] r_s5_r2ee;
    logic [HHW-1:0]        r_s5_hh;
    logic [HLW-1:0]        r_s5_hl;
    logic [LLW-1:0]        r_s5_ll;
    logic [SHW-1:0]        r_s5_sh;
    logic [SLW-1:0]        r_s5_sl;
    logic [NAPH-1:0]       w_nap_hi;
    logic [NAPL-1:0]       w_nap_lo;

    assign w_nap_hi = r_s4_napmag[NAPW-1:NAPL];
    assign w_nap_lo = r_s4_napmag[NAPL-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s5_tag  <= r_s4_tag;
            r_s5_vvee <= PVW'(r_s4_vv) * PVW'(r_s4_ee);
            r_s5_vesq <= PVW'(r_s4_ve) * PVW'(r_s4_ve);
            r_s5_r2ee <= RPW'($signed({1'b0, i_r2})) * RPW'(r_s4_ee);
            r_s5_hh   <= HHW'(w_nap_hi) * HHW'(w_nap_hi);
            r_s5_hl   <= HLW'(w_nap_hi) * HLW'(w_nap_lo);
            r_s5_ll   <= LLW'(w_nap_lo) * LLW'(w_nap_lo);
            r_s5_sh   <= SHW'(i_r2) * SHW'(r_s4_nn[NNW-1:NNL]);
            r_s5_sl   <= SLW'(i_r2) * SLW'(r_s4_nn[NNL-1:0]);
        end
    end

    // stage 6: assemble both sides of each compare
    t_tag                  r_s6_tag;
    logic signed [EW-1:0]  r_s6_elhs;
    logic signed [RPW-1:0] r_s6_erhs;
    logic [FW-1:0]         r_s6_flhs, r_s6_frhs;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s6_tag  <= r_s5_tag;
            r_s6_elhs <= EW'(r_s5_vvee) - EW'(r_s5_vesq);
            r_s6_erhs <= r_s5_r2ee;
            r_s6_flhs <= (FW'(r_s5_hh) << (2 * NAPL)) + (FW'(r_s5_hl) << (NAPL + 1))
                       + FW'(r_s5_ll);
            r_s6_frhs <= (FW'(r_s5_sh) << NNL) + FW'(r_s5_sl);
        end
    end

    // stage 7: output register
    logic          n_hit;
    logic          r_s7_hit;
    logic [RW-1:0] r_s7_region;

    assign n_hit = r_s6_tag.base
                || (r_s6_tag.edge_en && (r_s6_elhs <= EW'(r_s6_erhs)))
                || (r_s6_tag.face_en && (r_s6_flhs <= r_s6_frhs));

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s7_hit    <= n_hit;
            r_s7_region <= r_s6_tag.region;
        end
    end

    assign o_hit    = r_s7_hit;
    assign o_region = r_s7_region;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the sphere-triangle overlap tester: streams triangles, checks region and hit.
module testbench;
    import sto_pkg::*;

    localparam int     HALF_PERIOD   = 10;
    localparam int     MAX_WAIT      = 12;
    localparam int     SETTLE_CYCLES = 16;      // pipeline is seven stages deep
    localparam int     RANDOM_PHASES = 12;
    localparam int     PHASE_REQS    = 96;
    localparam int     MAX_REPORTS   = 10;
    localparam longint TIMEOUT_NS    = 4_000_000;
    localparam int     COORD_MAX     = (1 << (CW - 1)) - 1;
    localparam int     COORD_MIN     = -(1 << (CW - 1));

    // Register map of the configuration port.
    typedef enum logic [3:0] {
        ADDR_CENTER_X = 4'h0,
        ADDR_CENTER_Y = 4'h4,
        ADDR_CENTER_Z = 4'h8,
        ADDR_RADIUS   = 4'hC
    } reg_addr_e;

    // Closest-feature codes reported on o_nearest_region.
    typedef enum logic [RW-1:0] {
        RGN_VERT_A  = 3'd0,
        RGN_VERT_B  = 3'd1,
        RGN_EDGE_AB = 3'd2,
        RGN_VERT_C  = 3'd3,
        RGN_EDGE_AC = 3'd4,
        RGN_EDGE_BC = 3'd5,
        RGN_FACE    = 3'd6
    } region_e;

    typedef logic signed [63:0]  sword_t;
    typedef logic signed [255:0] wide_t;
    typedef struct packed { sword_t x, y, z; } dvec_t;
    typedef struct packed { logic hit; region_e region; } overlap_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [3:0]    paddr   = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          i_valid = 1'b0;
    logic          o_stall;
    t_tri          drv_tri = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic          o_hit;
    logic [RW-1:0] o_nearest_region;

    // Shadow copy of the sphere registers, as reset leaves them.
    t_vec          cfg_center = '0;
    logic [CW-1:0] cfg_radius = '0;

    t_tri     tri_backlog[$];          // triangles not yet offered to the block
    overlap_t expected_overlaps[$];    // predicted outcome per accepted request
    int       reqs_queued  = 0;
    int       results_seen = 0;
    int       err_count    = 0;
    logic     req_taken    = 1'b0;
    logic     res_taken    = 1'b0;
    int       req_gap      = 0;
    int       stall_left   = 0;
    logic     req_calm     = 1'b0;
    logic     res_calm     = 1'b0;

    sphere_triangle_overlap_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_vert_a_x       (drv_tri.a.x),
        .i_vert_a_y       (drv_tri.a.y),
        .i_vert_a_z       (drv_tri.a.z),
        .i_vert_b_x       (drv_tri.b.x),
        .i_vert_b_y       (drv_tri.b.y),
        .i_vert_b_z       (drv_tri.b.z),
        .i_vert_c_x       (drv_tri.c.x),
        .i_vert_c_y       (drv_tri.c.y),
        .i_vert_c_z       (drv_tri.c.z),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hit            (o_hit),
        .o_nearest_region (o_nearest_region)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Exact integer predictor of the closest-feature test
    // ------------------------------------------------------------------
    function automatic logic signed [CW-1:0] clamp_coord(input int v);
        if (v > COORD_MAX) return COORD_MAX[CW-1:0];
        if (v < COORD_MIN) return COORD_MIN[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic t_vec mk_vec(input int x, input int y, input int z);
        t_vec v;
        v.x = clamp_coord(x);
        v.y = clamp_coord(y);
        v.z = clamp_coord(z);
        return v;
    endfunction

    function automatic dvec_t widen(input t_vec v);
        dvec_t w;
        w.x = v.x;
        w.y = v.y;
        w.z = v.z;
        return w;
    endfunction

    function automatic dvec_t vsub(input dvec_t u, input dvec_t v);
        dvec_t w;
        w.x = u.x - v.x;
        w.y = u.y - v.y;
        w.z = u.z - v.z;
        return w;
    endfunction

    function automatic sword_t dot3(input dvec_t u, input dvec_t v);
        return u.x * v.x + u.y * v.y + u.z * v.z;
    endfunction

    function automatic wide_t wmul(input sword_t x, input sword_t y);
        wide_t xw, yw;
        xw = x;
        yw = y;
        return xw * yw;
    endfunction

    // Distance test against the line through a vertex along e, divisions cross-multiplied.
    function automatic logic edge_touch(input sword_t vv, input sword_t ee, input sword_t ve,
                                        input sword_t r2);
        // a zero-length edge falls back to the distance to its start vertex
        if (ee == 0) return vv <= r2;
        return (wmul(vv, ee) - wmul(ve, ve)) <= wmul(r2, ee);
    endfunction

    function automatic overlap_t predict_overlap(input t_tri t);
        dvec_t    a, b, c, p, ab, ac, bc, ap, bp, cp, n;
        sword_t   d1, d2, d3, d4, d5, d6, r2;
        wide_t    vc, vb, va, nn, nap, r2w;
        overlap_t res;
        a  = widen(t.a);
        b  = widen(t.b);
        c  = widen(t.c);
        p  = widen(cfg_center);
        ab = vsub(b, a);
        ac = vsub(c, a);
        bc = vsub(c, b);
        ap = vsub(p, a);
        bp = vsub(p, b);
        cp = vsub(p, c);
        r2 = cfg_radius;
        r2 = r2 * r2;
        r2w = r2;

        // vertex A within reach counts whatever region wins
        res.hit = dot3(ap, ap) <= r2;

        d1 = dot3(ab, ap);
        d2 = dot3(ac, ap);
        d3 = dot3(ab, bp);
        d4 = dot3(ac, bp);
        d5 = dot3(ab, cp);
        d6 = dot3(ac, cp);
        vc = wmul(d1, d4) - wmul(d3, d2);
        vb = wmul(d5, d2) - wmul(d1, d6);
        va = wmul(d3, d6) - wmul(d5, d4);

        if (d1 <= 0 && d2 <= 0) begin
            res.region = RGN_VERT_A;
        end else if (d3 >= 0 && d4 <= d3) begin
            res.region = RGN_VERT_B;
            res.hit |= dot3(bp, bp) <= r2;
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            res.region = RGN_EDGE_AB;
            res.hit |= edge_touch(dot3(ap, ap), dot3(ab, ab), d1, r2);
        end else if (d6 >= 0 && d5 <= d6) begin
            res.region = RGN_VERT_C;
            res.hit |= dot3(cp, cp) <= r2;
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            res.region = RGN_EDGE_AC;
            res.hit |= edge_touch(dot3(ap, ap), dot3(ac, ac), d2, r2);
        end else if (va <= 0 && (d4 - d3) >= 0 && (d5 - d6) >= 0) begin
            res.region = RGN_EDGE_BC;
            res.hit |= edge_touch(dot3(bp, bp), dot3(bc, bc), dot3(bp, bc), r2);
        end else begin
            res.region = RGN_FACE;
            n.x = ab.y * ac.z - ab.z * ac.y;
            n.y = ab.z * ac.x - ab.x * ac.z;
            n.z = ab.x * ac.y - ab.y * ac.x;
            nn  = wmul(n.x, n.x) + wmul(n.y, n.y) + wmul(n.z, n.z);
            nap = wmul(n.x, ap.x) + wmul(n.y, ap.y) + wmul(n.z, ap.z);
            // a zero-area face never hits on its own
            if (nn > 0) res.hit |= (nap * nap) <= (r2w * nn);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random triangle generation
    // ------------------------------------------------------------------
    function automatic logic signed [CW-1:0] rand_coord();
        logic [31:0] raw;
        raw = $urandom;
        return raw[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] extreme_coord();
        case ($urandom_range(0, 3))
            0:       return COORD_MIN[CW-1:0];
            1:       return COORD_MAX[CW-1:0];
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Pick a spread around the sphere: tight, comparable to the radius, or wide.
    function automatic int pick_spread();
        case ($urandom_range(0, 4))
            0:       return 4;
            1:       return 64;
            2:       return int'(cfg_radius) + 8;
            3:       return 2000;
            default: return 30000;
        endcase
    endfunction

    function automatic t_vec near_vec(input int spread);
        t_vec v;
        int   off;
        off = $urandom_range(0, 2 * spread);
        v.x = clamp_coord(int'(cfg_center.x) + off - spread);
        off = $urandom_range(0, 2 * spread);
        v.y = clamp_coord(int'(cfg_center.y) + off - spread);
        off = $urandom_range(0, 2 * spread);
        v.z = clamp_coord(int'(cfg_center.z) + off - spread);
        return v;
    endfunction

    function automatic t_tri random_tri();
        t_tri t;
        int   pick, spread;
        pick   = $urandom_range(0, 99);
        spread = pick_spread();
        t.a = near_vec(spread);
        t.b = near_vec(spread);
        t.c = near_vec(spread);
        if (pick >= 55 && pick < 70) begin
            // fold the triangle: shared vertices or a straight line
            case ($urandom_range(0, 3))
                0:       t.b = t.a;
                1:       t.c = t.a;
                2:       t.c = t.b;
                default: t.c = mk_vec(2 * t.b.x - t.a.x, 2 * t.b.y - t.a.y,
                                      2 * t.b.z - t.a.z);
            endcase
        end else if (pick >= 70 && pick < 85) begin
            t.a.x = rand_coord(); t.a.y = rand_coord(); t.a.z = rand_coord();
            t.b.x = rand_coord(); t.b.y = rand_coord(); t.b.z = rand_coord();
            t.c.x = rand_coord(); t.c.y = rand_coord(); t.c.z = rand_coord();
        end else if (pick >= 85) begin
            t.a.x = extreme_coord(); t.a.y = extreme_coord(); t.a.z = extreme_coord();
            t.b.x = extreme_coord(); t.b.y = extreme_coord(); t.b.z = extreme_coord();
            t.c.x = extreme_coord(); t.c.y = extreme_coord(); t.c.z = extreme_coord();
        end
        return t;
    endfunction

    function automatic t_vec pick_center();
        t_vec v;
        case ($urandom_range(0, 3))
            0: v = '0;
            1, 2: begin
                v.x = rand_coord();
                v.y = rand_coord();
                v.z = rand_coord();
            end
            default: begin
                v.x = $urandom_range(0, 1) ? COORD_MAX[CW-1:0] : COORD_MIN[CW-1:0];
                v.y = $urandom_range(0, 1) ? COORD_MAX[CW-1:0] : COORD_MIN[CW-1:0];
                v.z = $urandom_range(0, 1) ? COORD_MAX[CW-1:0] : COORD_MIN[CW-1:0];
            end
        endcase
        return v;
    endfunction

    function automatic logic [CW-1:0] pick_radius();
        logic [31:0] raw;
        case ($urandom_range(0, 4))
            0:       raw = 0;
            1:       raw = 32'hFFFF;
            2:       raw = $urandom_range(0, 64);
            3:       raw = $urandom_range(0, 4096);
            default: raw = $urandom_range(0, 65535);
        endcase
        return raw[CW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Error log: print the first few, count the rest
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("ERROR: %s", msg);
    endtask

    // ------------------------------------------------------------------
    // Configuration port: setup cycle, then access cycle
    // ------------------------------------------------------------------
    task automatic apb_write(input reg_addr_e addr, input logic [CW-1:0] value);
        logic [31:0] junk;
        junk = $urandom;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        // fill the unused upper bits with noise; the block must ignore them
        pwdata  <= {junk[31:CW], value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        // mirror the write into the shadow registers at the write edge
        case (addr)
            ADDR_CENTER_X: cfg_center.x = value;
            ADDR_CENTER_Y: cfg_center.y = value;
            ADDR_CENTER_Z: cfg_center.z = value;
            ADDR_RADIUS:   cfg_radius   = value;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input reg_addr_e addr, output logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Load a sphere, read every register back, and hand over on a rising edge
    // so that queued triangles never race the driver at the falling edge.
    task automatic configure_sphere(input t_vec ctr, input logic [CW-1:0] radius);
        reg_addr_e     addr;
        logic [31:0]   got;
        logic [CW-1:0] want;
        apb_write(ADDR_CENTER_X, ctr.x);
        apb_write(ADDR_CENTER_Y, ctr.y);
        apb_write(ADDR_CENTER_Z, ctr.z);
        apb_write(ADDR_RADIUS, radius);
        addr = addr.first();
        repeat (addr.num()) begin
            apb_read(addr, got);
            case (addr)
                ADDR_CENTER_X: want = cfg_center.x;
                ADDR_CENTER_Y: want = cfg_center.y;
                ADDR_CENTER_Z: want = cfg_center.z;
                ADDR_RADIUS:   want = cfg_radius;
            endcase
            if (got[CW-1:0] !== want)
                flag_error($sformatf("register %s reads %h, expected %h",
                                     addr.name(), got[CW-1:0], want));
            addr = addr.next();
        end
        @(posedge i_clk);
    endtask

    task automatic push_tri(input t_tri t);
        tri_backlog.push_back(t);
        reqs_queued++;
    endtask

    // Place a right triangle of legs 100 so that the sphere center (at the
    // origin) sits at offset q from vertex A: walks P through every region.
    task automatic push_region_probes();
        int qx[8], qy[8], qz[8];
        t_tri t;
        qx = '{-10, 110,  50, -10, -10, 60, 20,  20};
        qy = '{-10, -10, -10, 110,  50, 60, 20,  20};
        qz = '{  5,   5,   5,   5,   5,  5,  5, 300};
        for (int k = 0; k < 8; k++) begin
            t.a = mk_vec(-qx[k], -qy[k], -qz[k]);
            t.b = mk_vec(100 - qx[k], -qy[k], -qz[k]);
            t.c = mk_vec(-qx[k], 100 - qy[k], -qz[k]);
            push_tri(t);
        end
    endtask

    // Wait until every request has produced its result, then let the pipe settle.
    task automatic wait_idle();
        do @(negedge i_clk); while (results_seen < reqs_queued);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        overlap_t want;
        res_taken = (o_valid === 1'b1) && (i_stall === 1'b0);
        req_taken = (i_valid === 1'b1) && (o_stall === 1'b0);
        // Check the outgoing result before recording the incoming request.
        if (res_taken) begin
            results_seen++;
            if (expected_overlaps.size() == 0) begin
                flag_error($sformatf("result with nothing pending: hit %0b region %0d",
                                     o_hit, o_nearest_region));
            end else begin
                want = expected_overlaps.pop_front();
                if (o_hit !== want.hit || o_nearest_region !== want.region)
                    flag_error($sformatf("result %0d: hit %0b region %0d, expected hit %0b region %0d",
                                         results_seen, o_hit, o_nearest_region,
                                         want.hit, want.region));
            end
        end
        if (req_taken) expected_overlaps.push_back(predict_overlap(drv_tri));
    end

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge only
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        logic nxt_valid, nxt_stall;
        t_tri nxt_tri;
        // Hold the request until it is taken; drop valid once it is.
        nxt_valid = i_valid && !req_taken;
        nxt_tri   = drv_tri;
        if (!nxt_valid) begin
            if (req_gap > 0) begin
                req_gap--;
            end else if (tri_backlog.size() != 0) begin
                nxt_tri   = tri_backlog.pop_front();
                nxt_valid = 1'b1;
                // now and then switch between bursts and gappy traffic
                if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
                req_gap = req_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
        end
        // Draw a fresh output stall for each result taken.
        if (res_taken) begin
            if ($urandom_range(0, 31) == 0) res_calm = !res_calm;
            stall_left = res_calm ? 0 : $urandom_range(0, MAX_WAIT);
        end
        nxt_stall = (stall_left > 0);
        if (stall_left > 0) stall_left--;
        i_valid <= nxt_valid;
        drv_tri <= nxt_tri;
        i_stall <= nxt_stall;
    end

    // ------------------------------------------------------------------
    // Stimulus: directed probes, then random phases with fresh spheres
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_vec          ctr;
        logic [CW-1:0] radius;
        t_tri          t;

        // Hold reset from time zero, then release it at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Sphere at the origin large enough to touch every probe but the far face.
        configure_sphere(mk_vec(0, 0, 0), 16'd100);
        push_region_probes();
        // degenerate triangles: a single point, a straight line,
        // a zero-length edge BC, and A coinciding with B
        t.a = mk_vec(3, 4, 0);    t.b = mk_vec(3, 4, 0);   t.c = mk_vec(3, 4, 0);
        push_tri(t);
        t.a = mk_vec(-10, 5, 0);  t.b = mk_vec(10, 5, 0);  t.c = mk_vec(30, 5, 0);
        push_tri(t);
        t.a = mk_vec(-60, 0, 0);  t.b = mk_vec(40, 0, 0);  t.c = mk_vec(40, 0, 0);
        push_tri(t);
        t.a = mk_vec(5, 5, 0);    t.b = mk_vec(5, 5, 0);   t.c = mk_vec(100, 5, 0);
        push_tri(t);
        wait_idle();

        // Same probes with a tiny sphere: every region misses.
        configure_sphere(mk_vec(0, 0, 0), 16'd3);
        push_region_probes();
        wait_idle();

        // Corner sphere of maximum radius against corner triangles.
        configure_sphere(mk_vec(COORD_MIN, COORD_MAX, COORD_MIN), '1);
        t.a = mk_vec(COORD_MIN, COORD_MIN, COORD_MIN);
        t.b = t.a;
        t.c = t.a;
        push_tri(t);
        t.a = mk_vec(COORD_MAX, COORD_MAX, COORD_MAX);
        t.b = t.a;
        t.c = t.a;
        push_tri(t);
        t.a = mk_vec(COORD_MAX, COORD_MAX, COORD_MAX);
        t.b = mk_vec(COORD_MIN, COORD_MIN, COORD_MIN);
        t.c = mk_vec(COORD_MAX, COORD_MIN, COORD_MIN);
        push_tri(t);
        t.a = mk_vec(COORD_MIN, COORD_MAX, COORD_MIN);
        t.b = mk_vec(COORD_MAX, COORD_MIN, COORD_MAX);
        t.c = mk_vec(COORD_MIN, COORD_MIN, COORD_MAX);
        push_tri(t);
        wait_idle();

        // Random phases; the first uses a zero radius, the last the opposite corner
        // with the largest radius.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            ctr    = pick_center();
            radius = pick_radius();
            if (ph == 0) radius = '0;
            if (ph == RANDOM_PHASES - 1) begin
                ctr    = mk_vec(COORD_MAX, COORD_MIN, COORD_MAX);
                radius = '1;
            end
            configure_sphere(ctr, radius);
            repeat (PHASE_REQS) push_tri(random_tri());
            wait_idle();
        end

        if (expected_overlaps.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_overlaps.size()));
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Give up if the run hangs.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
